// ----- rtl/core/nsb_pkg.sv -----
// Shared types and constants for the nearest smaller bound unit.
// No dependencies.
`timescale 1ns / 1ps

package nsb_pkg;

    localparam int LEN_W    = 13;
    localparam int HEIGHT_W = 32;
    localparam int CFG_AW   = 1;
    localparam int TDATA_W  = 32;
    localparam int MDATA_W  = 16;

    localparam logic [CFG_AW-1:0] CFG_REVERSE = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_LENGTH  = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]           pos;
        logic signed [HEIGHT_W-1:0] height;
    } entry_t;

endpackage

// ----- rtl/core/nsb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/nearest_smaller_bound_unit.sv -----
// Nearest smaller bound unit: each signed height is matched against a stack
// of earlier (position, height) entries kept in one synchronous RAM; entries
// with a height greater than or equal to the new one are popped, and the one
// left on top gives the inclusive span bound (left bound in forward mode,
// right bound in reverse mode, where items arrive last to first). One item is
// worked at a time: it is accepted, then compared and pushed; every entry it
// pops adds a compare and a reload of the new top from one registered RAM
// read of the entry below, except a pop that empties the stack, which adds
// only the compare. An item pops on average at most one entry. A result
// waits in an output register while the next item is already taken; a held
// result stalls the push. Depends on nsb_pkg and nsb_ram.
`timescale 1ns / 1ps

module nearest_smaller_bound_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: height[31:0]
    input  logic [nsb_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // m_tdata: bound_index[12:0], zero fill[15:13]
    output logic [nsb_pkg::MDATA_W-1:0]  m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_we,
    input  logic [nsb_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [nsb_pkg::LEN_W-1:0]    cfg_wdata
);

    import nsb_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_LEN + 1);
    localparam int EW = $bits(entry_t);

    state_t                     state_reg, state_next;
    logic                       rev_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [DW-1:0]              depth_reg, depth_next;
    logic [LEN_W-1:0]           pc_reg, pc_next;
    entry_t                     top_reg, top_next;
    logic signed [HEIGHT_W-1:0] h_reg, h_next;
    logic                       last_reg, last_next;
    logic                       out_vld_reg, out_vld_next;
    logic [LEN_W-1:0]           bound_reg, bound_next;

    logic [LEN_W-1:0] n_eff;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] pc_inc;
    logic [LEN_W-1:0] bound;
    logic [DW-1:0]    depth_m2;
    entry_t           new_entry;
    logic             ram_we;
    logic [EW-1:0]    ram_rdata;

    always_comb begin
        if (len_reg == '0) begin
            n_eff = LEN_W'(1);
        end else if (32'(len_reg) > MAX_LEN) begin
            n_eff = LEN_W'(MAX_LEN);
        end else begin
            n_eff = len_reg;
        end
    end

    assign pc_inc   = pc_reg + LEN_W'(1);
    assign pos      = rev_reg ? (n_eff - pc_reg) : pc_inc;
    assign depth_m2 = depth_reg - DW'(2);

    always_comb begin
        if (rev_reg) begin
            bound = (depth_reg == '0) ? n_eff : (top_reg.pos - LEN_W'(1));
        end else begin
            bound = (depth_reg == '0) ? LEN_W'(1) : (top_reg.pos + LEN_W'(1));
        end
    end

    assign new_entry.pos    = pos;
    assign new_entry.height = h_reg;

    nsb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (depth_reg[AW-1:0]),
        .wdata (new_entry),
        .raddr (depth_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        pc_next      = pc_reg;
        top_next     = top_reg;
        h_next       = h_reg;
        last_next    = last_reg;
        out_vld_next = out_vld_reg;
        bound_next   = bound_reg;
        ram_we       = 1'b0;
        s_tready     = (state_reg == ST_IDLE);

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    h_next    = s_tdata;
                    last_next = s_tlast;
                    if (pc_reg >= n_eff || 32'(depth_reg) >= MAX_LEN) begin
                        depth_next = '0;
                        pc_next    = '0;
                    end
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (depth_reg != '0 && top_reg.height >= h_reg) begin
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg != DW'(1)) begin
                        state_next = ST_LOAD;
                    end
                end else if (!out_vld_reg || m_tready) begin
                    ram_we       = 1'b1;
                    top_next     = new_entry;
                    depth_next   = depth_reg + DW'(1);
                    pc_next      = pc_inc;
                    if (last_reg || pc_inc >= n_eff) begin
                        depth_next = '0;
                        pc_next    = '0;
                    end
                    out_vld_next = 1'b1;
                    bound_next   = bound;
                    state_next   = ST_IDLE;
                end
            end
            ST_LOAD: begin
                top_next   = ram_rdata;
                state_next = ST_CMP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rev_reg     <= 1'b0;
            len_reg     <= LEN_W'(4096);
            depth_reg   <= '0;
            pc_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            pc_reg      <= pc_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_REVERSE: rev_reg <= cfg_wdata[0];
                    CFG_LENGTH:  len_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg   <= top_next;
        h_reg     <= h_next;
        last_reg  <= last_next;
        bound_reg <= bound_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = MDATA_W'(bound_reg);

    a_depth_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= 32'(pc_reg))
        else $error("stack depth exceeds items taken");

    a_push_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg > $past(depth_reg) |-> depth_reg == $past(depth_reg) + DW'(1))
        else $error("stack grew by more than one entry");

    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> depth_reg != '0)
        else $error("reload of top entry with empty stack");

endmodule
